FILE: design/rhr_pkg.sv
// ----------------------------------------------------------------------------
// rhr_pkg
// shared constants and the 0..45 degree sine/cosine tables for the hue rotator
// ----------------------------------------------------------------------------
package rhr_pkg;

    localparam int DEF_COEF_FRAC_BITS = 14;

    // register map
    localparam int ADDR_W       = 3;
    localparam int REG_ADDR_LSB = 2;
    localparam logic REG_HUE    = 1'b0;
    localparam int HUE_W        = 9;
    localparam int PIX_W        = 8;

    // q30 constants, with 1/3 in q33
    localparam int Q30_W                  = 31;
    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam logic [29:0] INV_SQRT3_Q30 = 30'd619925131;
    localparam logic [31:0] RECIP3_Q33    = 32'hAAAA_AAAB;

    localparam int TAB_DEPTH = 46;
    localparam int TAB_IDX_W = 6;

    typedef logic [Q30_W-1:0] t_q30_tab [0:TAB_DEPTH-1];

    localparam longint unsigned TS_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint unsigned TC_DIV [1:7] = '{2, 12, 30, 56, 90, 132, 182};

    // taylor series for 0..45 degrees, evaluated at elaboration
    function automatic t_q30_tab f_series_tab(input bit want_cos);
        t_q30_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint unsigned s;
        longint unsigned c;
        for (int d = 0; d < TAB_DEPTH; d++) begin
            x  = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
            x2 = (x * x) >> 30;
            ts = x;
            tc = Q30_ONE;
            s  = x;
            c  = Q30_ONE;
            for (int k = 1; k <= 7; k++) begin
                ts = ((ts * x2) >> 30) / TS_DIV[k];
                tc = ((tc * x2) >> 30) / TC_DIV[k];
                if (k % 2 == 1) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            tab[d] = want_cos ? c[Q30_W-1:0] : s[Q30_W-1:0];
        end
        return tab;
    endfunction

    localparam t_q30_tab SIN_TAB = f_series_tab(1'b0);
    localparam t_q30_tab COS_TAB = f_series_tab(1'b1);

endpackage

FILE: design/rhr_coef_unit.sv
// ----------------------------------------------------------------------------
// rhr_coef_unit
// hue register and five-step sequencer that turns the angle into the three
// circulant matrix coefficients
// ----------------------------------------------------------------------------
module rhr_coef_unit #(
    parameter int COEF_FRAC_BITS = rhr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [rhr_pkg::HUE_W-1:0]       i_wr_data,
    output logic [rhr_pkg::HUE_W-1:0]       o_hue,
    output logic                            o_busy,
    output logic signed [COEF_FRAC_BITS+2:0] o_diag_coef,
    output logic signed [COEF_FRAC_BITS+2:0] o_minus_coef,
    output logic signed [COEF_FRAC_BITS+2:0] o_plus_coef
);
    import rhr_pkg::*;

    localparam int CW    = COEF_FRAC_BITS + 3;
    localparam int SH    = 30 - COEF_FRAC_BITS;
    localparam int STEPS = 5;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [HUE_W-1:0]     r_hue;
    logic [STEPS-1:0]     r_seq;
    logic [1:0]           r_quad;
    logic                 r_swap;
    logic [TAB_IDX_W-1:0] r_idx;
    logic signed [31:0]   r_s;
    logic signed [31:0]   r_c;
    logic [Q30_W-1:0]     r_t;
    logic [Q30_W-1:0]     r_m;
    logic signed [31:0]   r_k;
    logic signed [CW-1:0] r_diag_coef;
    logic signed [CW-1:0] r_minus_coef;
    logic signed [CW-1:0] r_plus_coef;

    // step 1: angle reduction
    logic [HUE_W-1:0]     w_h;
    logic [1:0]           n_quad;
    logic [6:0]           w_r;
    logic                 n_swap;
    logic [TAB_IDX_W-1:0] n_idx;

    always_comb begin
        w_h = (r_hue >= HUE_W'(360)) ? r_hue - HUE_W'(360) : r_hue;
        if (w_h >= HUE_W'(270)) begin
            n_quad = QUAD_3;
            w_r    = 7'(w_h - HUE_W'(270));
        end else if (w_h >= HUE_W'(180)) begin
            n_quad = QUAD_2;
            w_r    = 7'(w_h - HUE_W'(180));
        end else if (w_h >= HUE_W'(90)) begin
            n_quad = QUAD_1;
            w_r    = 7'(w_h - HUE_W'(90));
        end else begin
            n_quad = QUAD_0;
            w_r    = 7'(w_h);
        end
        n_swap = (w_r > 7'd45);
        n_idx  = n_swap ? TAB_IDX_W'(7'd90 - w_r) : TAB_IDX_W'(w_r);
    end

    // step 2: table read and quadrant mapping
    logic [Q30_W-1:0]   w_s0;
    logic [Q30_W-1:0]   w_c0;
    logic signed [31:0] w_sp;
    logic signed [31:0] w_cp;
    logic signed [31:0] n_s;
    logic signed [31:0] n_c;

    always_comb begin
        w_s0 = r_swap ? COS_TAB[r_idx] : SIN_TAB[r_idx];
        w_c0 = r_swap ? SIN_TAB[r_idx] : COS_TAB[r_idx];
        w_sp = $signed({1'b0, w_s0});
        w_cp = $signed({1'b0, w_c0});
        unique case (r_quad)
            QUAD_0: begin
                n_s = w_sp;
                n_c = w_cp;
            end
            QUAD_1: begin
                n_s = w_cp;
                n_c = -w_sp;
            end
            QUAD_2: begin
                n_s = -w_sp;
                n_c = -w_cp;
            end
            default: begin
                n_s = -w_cp;
                n_c = w_sp;
            end
        endcase
    end

    // step 3: t = (1 - c) / 3 by reciprocal, |s|
    logic signed [32:0] w_num;
    logic [63:0]        w_prod_t;
    logic [Q30_W-1:0]   n_t;
    logic signed [31:0] w_abs_s;
    logic [Q30_W-1:0]   n_m;

    always_comb begin
        w_num    = $signed(33'h0_4000_0000) - {r_c[31], r_c};
        w_prod_t = {32'd0, w_num[31:0]} * {32'd0, RECIP3_Q33};
        n_t      = w_prod_t[63:33];
        w_abs_s  = r_s[31] ? -r_s : r_s;
        n_m      = w_abs_s[Q30_W-1:0];
    end

    // step 4: k = |s| / sqrt(3), rounded, sign restored
    logic [61:0]        w_prod_k;
    logic [31:0]        w_k_mag;
    logic signed [31:0] n_k;

    always_comb begin
        w_prod_k = {31'd0, r_m} * {32'd0, INV_SQRT3_Q30} + (62'd1 << 29);
        w_k_mag  = w_prod_k[61:30];
        n_k      = r_s[31] ? -$signed(w_k_mag) : $signed(w_k_mag);
    end

    // step 5: sums and rounding to the coefficient format
    logic signed [33:0] w_t;
    logic signed [33:0] w_a;
    logic signed [33:0] w_b;
    logic signed [33:0] w_cc;
    logic signed [33:0] w_a_rnd;
    logic signed [33:0] w_b_rnd;
    logic signed [33:0] w_cc_rnd;

    always_comb begin
        w_t      = $signed({3'd0, r_t});
        w_a      = {{2{r_c[31]}}, r_c} + w_t;
        w_b      = w_t - {{2{r_k[31]}}, r_k};
        w_cc     = w_t + {{2{r_k[31]}}, r_k};
        w_a_rnd  = (w_a + (34'sd1 <<< (SH - 1))) >>> SH;
        w_b_rnd  = (w_b + (34'sd1 <<< (SH - 1))) >>> SH;
        w_cc_rnd = (w_cc + (34'sd1 <<< (SH - 1))) >>> SH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue        <= '0;
            r_seq        <= '0;
            r_diag_coef  <= CW'(1) <<< COEF_FRAC_BITS;
            r_minus_coef <= '0;
            r_plus_coef  <= '0;
        end else begin
            if (i_wr_en) begin
                r_hue <= i_wr_data;
            end
            r_seq <= {r_seq[STEPS-2:0], i_wr_en};
            if (r_seq[STEPS-1]) begin
                r_diag_coef  <= w_a_rnd[CW-1:0];
                r_minus_coef <= w_b_rnd[CW-1:0];
                r_plus_coef  <= w_cc_rnd[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_seq[0]) begin
            r_quad <= n_quad;
            r_swap <= n_swap;
            r_idx  <= n_idx;
        end
        if (r_seq[1]) begin
            r_s <= n_s;
            r_c <= n_c;
        end
        if (r_seq[2]) begin
            r_t <= n_t;
            r_m <= n_m;
        end
        if (r_seq[3]) begin
            r_k <= n_k;
        end
    end

    assign o_hue        = r_hue;
    assign o_busy       = |r_seq;
    assign o_diag_coef  = r_diag_coef;
    assign o_minus_coef = r_minus_coef;
    assign o_plus_coef  = r_plus_coef;

endmodule

FILE: design/rhr_pixel_pipe.sv
// ----------------------------------------------------------------------------
// rhr_pixel_pipe
// four-stage pixel datapath: input register, nine products, three sums,
// clamp into the output register
// ----------------------------------------------------------------------------
module rhr_pixel_pipe #(
    parameter int COEF_FRAC_BITS = rhr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [3*rhr_pkg::PIX_W-1:0]      i_pix,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [3*rhr_pkg::PIX_W-1:0]      o_pix,
    input  logic signed [COEF_FRAC_BITS+2:0] i_diag_coef,
    input  logic signed [COEF_FRAC_BITS+2:0] i_minus_coef,
    input  logic signed [COEF_FRAC_BITS+2:0] i_plus_coef
);
    import rhr_pkg::*;

    localparam int CW  = COEF_FRAC_BITS + 3;
    localparam int PW  = CW + 9;
    localparam int AW  = CW + 11;
    localparam int NST = 4;

    logic [NST-1:0]       r_vld;
    logic [NST-1:0]       w_adv;
    logic [PIX_W-1:0]     r_pix0 [3];
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [AW-1:0] r_acc  [3];
    logic [PIX_W-1:0]     r_out  [3];

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    logic signed [CW-1:0] w_coef [3];
    assign w_coef[0] = i_diag_coef;
    assign w_coef[1] = i_minus_coef;
    assign w_coef[2] = i_plus_coef;

    // channel ch uses coefficient (j - ch) mod 3 on component j
    logic signed [PW-1:0] n_prod [3][3];
    logic signed [AW-1:0] n_acc  [3];
    logic signed [AW-1:0] w_shift[3];
    logic [PIX_W-1:0]     n_out  [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[ch][j] = w_coef[(j + 3 - ch) % 3] * $signed({1'b0, r_pix0[j]});
            end
            n_acc[ch] = AW'(r_prod[ch][0]) + AW'(r_prod[ch][1]) + AW'(r_prod[ch][2]);
            w_shift[ch] = r_acc[ch] >>> COEF_FRAC_BITS;
            if (r_acc[ch][AW-1]) begin
                n_out[ch] = '0;
            end else if (|w_shift[ch][AW-1:PIX_W]) begin
                n_out[ch] = '1;
            end else begin
                n_out[ch] = w_shift[ch][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_pix0[j] <= i_pix[j*PIX_W +: PIX_W];
            end
        end
        if (w_adv[1]) r_prod <= n_prod;
        if (w_adv[2]) r_acc  <= n_acc;
        if (w_adv[3]) r_out  <= n_out;
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NST-1];
    assign o_pix   = {r_out[2], r_out[1], r_out[0]};

endmodule

FILE: design/rgb_hue_rotation.sv
// ----------------------------------------------------------------------------
// rgb_hue_rotation
// rotates the hue of 8-bit rgb pixels about the grey axis by a set angle
// ----------------------------------------------------------------------------
// pixels enter on the s_axis stream and leave on the m_axis stream, one item
// per pixel, red in the low byte of tdata, then green, then blue.
// the angle in whole degrees is written over the apb port at address 0
// (bits 8:0 of pwdata); reading it back returns the angle.
// m_axis_tvalid rises once an accepted item has passed four registers: input
// register, products, sums, clamp into the output register. one item per cycle
// is taken when the output is not stalled and no angle write is under way.
// a write of the angle starts the coefficient sequencer (angle reduction,
// table read, divide by three, scale by 1/sqrt(3), rounding); s_axis_tready
// is low during the write access and while the sequencer runs.
// reset clears the angle to 0, which makes the block pass pixels through
// unchanged, and empties the pipeline.
// when the receiver holds m_axis_tready low, the result stays in the output
// register and the earlier stages fill up; s_axis_tready falls once all four
// stages hold an item. nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_hue_rotation #(
    parameter int COEF_FRAC_BITS = rhr_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [3*rhr_pkg::PIX_W-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic [3*rhr_pkg::PIX_W-1:0]  m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rhr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rhr_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 3;

    logic                 w_wr_access;
    logic                 w_hue_sel;
    logic                 w_hue_wr;
    logic                 w_busy;
    logic                 w_pipe_ready;
    logic [HUE_W-1:0]     w_hue;
    logic signed [CW-1:0] w_diag_coef;
    logic signed [CW-1:0] w_minus_coef;
    logic signed [CW-1:0] w_plus_coef;

    assign pready      = 1'b1;
    assign w_wr_access = psel && penable && pwrite;
    assign w_hue_sel   = (paddr[REG_ADDR_LSB] == REG_HUE);
    assign w_hue_wr    = w_wr_access && w_hue_sel;
    assign prdata      = w_hue_sel ? {{(32-HUE_W){1'b0}}, w_hue} : 32'd0;

    rhr_coef_unit #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (w_hue_wr),
        .i_wr_data    (pwdata[HUE_W-1:0]),
        .o_hue        (w_hue),
        .o_busy       (w_busy),
        .o_diag_coef  (w_diag_coef),
        .o_minus_coef (w_minus_coef),
        .o_plus_coef  (w_plus_coef)
    );

    // no item enters while the coefficients are being rebuilt
    logic w_hold;
    assign w_hold        = w_busy || w_wr_access;
    assign s_axis_tready = w_pipe_ready && !w_hold;

    rhr_pixel_pipe #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid && !w_hold),
        .o_ready      (w_pipe_ready),
        .i_pix        (s_axis_tdata),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pix        (m_axis_tdata),
        .i_diag_coef  (w_diag_coef),
        .i_minus_coef (w_minus_coef),
        .i_plus_coef  (w_plus_coef)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("item accepted while coefficients are rebuilt");

    a_write_starts_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hue_wr |=> w_busy)
        else $error("angle write did not start the coefficient sequencer");

    a_hue_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hue_wr |=> (w_hue == $past(pwdata[HUE_W-1:0])))
        else $error("angle register does not hold the written value");

endmodule
